FILE: src/pitp_pkg.sv
// Shared widths, field codes and control structs for the table interpolator.
// No dependencies; every other file of the block but pitp_ram imports this package.
package pitp_pkg;

	localparam int MAX_POINTS = 16;
	localparam int PTR_W      = $clog2(MAX_POINTS);
	localparam int POINT_W    = 16;
	localparam int OUT_W      = 16;
	localparam int PHASE_W    = 16;
	localparam int CNT_W      = 5;
	localparam int IDX_W      = 4;
	localparam int PROD_W     = PHASE_W + CNT_W;
	localparam int TAPS       = 4;

	// stream payload layout
	localparam int S_DATA_W   = 40;
	localparam int M_DATA_W   = 48;

	// datapath widths of the cubic and linear terms
	localparam int A0_W  = POINT_W + 2;
	localparam int A1_W  = POINT_W + 3;
	localparam int A2_W  = POINT_W + 1;
	localparam int D_W   = POINT_W + 1;
	localparam int TX_W  = PHASE_W + 1;
	localparam int P1_W  = A0_W + TX_W;
	localparam int PL_W  = D_W + TX_W;
	localparam int V_W   = POINT_W + 5;
	localparam int PV_W  = V_W + TX_W;

	localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_POINTS);
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_EVAL  = 1'b1;

	typedef logic signed [POINT_W-1:0] point_t;
	typedef logic [TAPS-1:0][POINT_W-1:0] taps_t;

	typedef struct packed {
		logic                        wr_en;
		logic [PTR_W-1:0]            wr_idx;
		logic [POINT_W-1:0]          wr_val;
		logic                        rd_en;
		logic [TAPS-1:0][PTR_W-1:0]  rd_addr;
	} tbl_req_t;

	typedef struct packed {
		logic ld_s4;
		logic ld_s5;
		logic ld_s6;
		logic ld_s7;
		logic ld_s8;
	} ctl_t;

endpackage

FILE: src/phase_indexed_table_interpolator_core.sv
// Phase-indexed table interpolator, top level.
// Depends on pitp_pkg, pitp_table and pitp_interp.
//
// Input stream s_*: s_tuser selects the item kind. A point-write transfer stores
// one 16-bit table point and gives no result; an evaluate transfer looks the
// table up at a 16-bit phase and gives one result with step, linear and
// four-point cubic values (Q2.13, signed, linear and cubic saturated).
// Output stream m_*: one transfer per evaluate item, in input order.
// cfg_wen/cfg_wdata set the number of points in use (clamped to 2..16); write
// it only while the pipeline is empty.
//
// Throughput: one item per cycle while the receiver takes results. Each of the
// eight pipeline stages holds one item; the table is read once per evaluate item
// in stage 2. Each result passes through stages s1 to s8 on its way to m_tdata.
// A stalled receiver holds m_tvalid and m_tdata; empty stages keep filling, and
// s_tready drops only once every stage holds an item.
// Reset: the pipeline empties, the point count returns to 2 and every table
// point reads as zero until written.
module phase_indexed_table_interpolator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pitp_pkg::S_DATA_W-1:0]  s_tdata,  // point_index, point_value, phase, zero pad
	input  logic                           s_tuser,  // func
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pitp_pkg::M_DATA_W-1:0]  m_tdata,  // step_value, linear_value, cubic_value
	input  logic                           cfg_wen,
	input  logic [pitp_pkg::CNT_W-1:0]     cfg_wdata
);
	import pitp_pkg::*;

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] x,
		input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] s;
		s = CNT_W'(x) + CNT_W'(1);
		return (s >= n) ? PTR_W'(s - n) : PTR_W'(s);
	endfunction

	logic [CNT_W-1:0] cnt_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;

	logic               func_s1, func_s2;
	logic [IDX_W-1:0]   widx_s1, widx_s2;
	logic [POINT_W-1:0] pval_s1, pval_s2;
	logic [PHASE_W-1:0] phase_s1;
	logic [PTR_W-1:0]   idx_s2;
	logic [PHASE_W-1:0] t_s2, t_s3;

	logic [PROD_W-1:0]  prod;
	tbl_req_t           req;
	ctl_t               ctl;
	taps_t              taps;

	// ready chain: a stage takes a new item when empty or when it drains
	assign rdy_s8 = !vld_s8 || m_tready;
	assign rdy_s7 = !vld_s7 || rdy_s8;
	assign rdy_s6 = !vld_s6 || rdy_s7;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign m_tvalid = vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= CNT_RESET;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (cfg_wen) begin
				if (cfg_wdata < CNT_MIN) begin
					cnt_q <= CNT_MIN;
				end else if (cfg_wdata > CNT_MAX) begin
					cnt_q <= CNT_MAX;
				end else begin
					cnt_q <= cfg_wdata;
				end
			end
			if (rdy_s1) vld_s1 <= s_tvalid;
			if (rdy_s2) vld_s2 <= vld_s1;
			// drop write items once they have updated the table
			if (rdy_s3) vld_s3 <= vld_s2 && (func_s2 == FUNC_EVAL);
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
			if (rdy_s8) vld_s8 <= vld_s7;
		end
	end

	assign prod = PROD_W'(phase_s1) * PROD_W'(cnt_q);

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			func_s1  <= s_tuser;
			widx_s1  <= s_tdata[IDX_W-1:0];
			pval_s1  <= s_tdata[IDX_W+POINT_W-1:IDX_W];
			phase_s1 <= s_tdata[IDX_W+POINT_W+PHASE_W-1:IDX_W+POINT_W];
		end
		if (rdy_s2 && vld_s1) begin
			func_s2 <= func_s1;
			widx_s2 <= widx_s1;
			pval_s2 <= pval_s1;
			idx_s2  <= prod[PHASE_W+PTR_W-1:PHASE_W];
			t_s2    <= prod[PHASE_W-1:0];
		end
		if (req.rd_en) begin
			t_s3 <= t_s2;
		end
	end

	// table access happens as the item leaves stage 2, so order is kept
	always_comb begin
		req.wr_en      = rdy_s3 && vld_s2 && (func_s2 == FUNC_WRITE);
		req.wr_idx     = PTR_W'(widx_s2);
		req.wr_val     = pval_s2;
		req.rd_en      = rdy_s3 && vld_s2 && (func_s2 == FUNC_EVAL);
		req.rd_addr[0] = idx_s2;
		req.rd_addr[1] = wrap_next(idx_s2, cnt_q);
		req.rd_addr[2] = wrap_next(req.rd_addr[1], cnt_q);
		req.rd_addr[3] = wrap_next(req.rd_addr[2], cnt_q);
	end

	always_comb begin
		ctl.ld_s4 = rdy_s4 && vld_s3;
		ctl.ld_s5 = rdy_s5 && vld_s4;
		ctl.ld_s6 = rdy_s6 && vld_s5;
		ctl.ld_s7 = rdy_s7 && vld_s6;
		ctl.ld_s8 = rdy_s8 && vld_s7;
	end

	pitp_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.taps   (taps)
	);

	pitp_interp u_interp (
		.clk    (clk),
		.ctl    (ctl),
		.taps   (taps),
		.t_s3   (t_s3),
		.result (m_tdata)
	);

endmodule

FILE: src/pitp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No package dependency.
module pitp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/pitp_table.sv
// Point table: four RAM copies for four reads per cycle, plus per-entry valid bits
// so unwritten entries read as zero. Depends on pitp_pkg and pitp_ram.
module pitp_table (
	input  logic              clk,
	input  logic              arst_n,
	input  pitp_pkg::tbl_req_t req,
	output pitp_pkg::taps_t   taps
);
	import pitp_pkg::*;

	logic [MAX_POINTS-1:0] ent_vld_q;
	logic [TAPS-1:0]       rd_vld_q;
	taps_t                 raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			rd_vld_q  <= '0;
		end else begin
			if (req.wr_en) begin
				ent_vld_q[req.wr_idx] <= 1'b1;
			end
			if (req.rd_en) begin
				for (int k = 0; k < TAPS; k++) begin
					rd_vld_q[k] <= ent_vld_q[req.rd_addr[k]];
				end
			end
		end
	end

	for (genvar k = 0; k < TAPS; k++) begin : g_copy
		pitp_ram #(
			.WIDTH (POINT_W),
			.DEPTH (MAX_POINTS)
		) u_ram (
			.clk   (clk),
			.we    (req.wr_en),
			.waddr (req.wr_idx),
			.wdata (req.wr_val),
			.re    (req.rd_en),
			.raddr (req.rd_addr[k]),
			.rdata (raw[k])
		);

		// never-written entries read as zero
		assign taps[k] = rd_vld_q[k] ? raw[k] : '0;
	end

endmodule

FILE: src/pitp_interp.sv
// Arithmetic stages s4..s8: cubic coefficients, three Horner multiplies, linear
// term and output saturation. Depends on pitp_pkg; stage loads come from the top.
module pitp_interp (
	input  logic                    clk,
	input  pitp_pkg::ctl_t          ctl,
	input  pitp_pkg::taps_t         taps,
	input  logic [pitp_pkg::PHASE_W-1:0] t_s3,
	output logic [pitp_pkg::M_DATA_W-1:0] result
);
	import pitp_pkg::*;

	function automatic logic [OUT_W-1:0] sat_out(input logic signed [V_W-1:0] v);
		logic signed [V_W-1:0] hi;
		logic signed [V_W-1:0] lo;
		hi = V_W'(32767);
		lo = -V_W'(32768);
		if (v > hi) begin
			return OUT_W'(hi);
		end else if (v < lo) begin
			return OUT_W'(lo);
		end
		return v[OUT_W-1:0];
	endfunction

	point_t y0, y1, y2, y3;
	logic signed [A0_W-1:0] a0;
	logic signed [A1_W-1:0] a1;
	logic signed [A2_W-1:0] a2;
	logic signed [D_W-1:0]  d;

	assign y0 = point_t'(taps[0]);
	assign y1 = point_t'(taps[1]);
	assign y2 = point_t'(taps[2]);
	assign y3 = point_t'(taps[3]);

	assign a0 = A0_W'(y3) - A0_W'(y2) - A0_W'(y0) + A0_W'(y1);
	assign a1 = A1_W'(y0) - A1_W'(y1) - A1_W'(a0);
	assign a2 = A2_W'(y2) - A2_W'(y0);
	assign d  = D_W'(y1) - D_W'(y0);

	// s4: coefficients
	logic signed [A0_W-1:0]  a0_s4;
	logic signed [A1_W-1:0]  a1_s4;
	logic signed [A2_W-1:0]  a2_s4;
	point_t                  a3_s4, y0_s4;
	logic signed [D_W-1:0]   d_s4;
	logic [PHASE_W-1:0]      t_s4;

	// s5: first products
	logic signed [P1_W-1:0]  p1_s5;
	logic signed [PL_W-1:0]  pl_s5;
	logic signed [A1_W-1:0]  a1_s5;
	logic signed [A2_W-1:0]  a2_s5;
	point_t                  a3_s5, y0_s5;
	logic [PHASE_W-1:0]      t_s5;

	// s6: second Horner product
	logic signed [PV_W-1:0]  p2_s6;
	logic signed [PL_W-1:0]  pl_s6;
	logic signed [A2_W-1:0]  a2_s6;
	point_t                  a3_s6, y0_s6;
	logic [PHASE_W-1:0]      t_s6;

	// s7: third Horner product
	logic signed [PV_W-1:0]  p3_s7;
	logic signed [PL_W-1:0]  pl_s7;
	point_t                  a3_s7, y0_s7;

	// s8: output register
	logic [OUT_W-1:0] step_s8, lin_s8, cub_s8;

	logic signed [TX_W-1:0] tx_s4, tx_s5, tx_s6;
	logic signed [V_W-1:0]  v1, v2, v3, lin;

	assign tx_s4 = $signed({1'b0, t_s4});
	assign tx_s5 = $signed({1'b0, t_s5});
	assign tx_s6 = $signed({1'b0, t_s6});

	// floor(p / 65536) is the upper part of each product
	assign v1  = V_W'($signed(p1_s5[P1_W-1:PHASE_W])) + V_W'(a1_s5);
	assign v2  = $signed(p2_s6[PHASE_W+V_W-1:PHASE_W]) + V_W'(a2_s6);
	assign v3  = $signed(p3_s7[PHASE_W+V_W-1:PHASE_W]) + V_W'(a3_s7);
	assign lin = V_W'($signed(pl_s7[PL_W-1:PHASE_W])) + V_W'(y0_s7);

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			a0_s4 <= a0;
			a1_s4 <= a1;
			a2_s4 <= a2;
			a3_s4 <= y1;
			y0_s4 <= y0;
			d_s4  <= d;
			t_s4  <= t_s3;
		end
		if (ctl.ld_s5) begin
			p1_s5 <= a0_s4 * tx_s4;
			pl_s5 <= d_s4 * tx_s4;
			a1_s5 <= a1_s4;
			a2_s5 <= a2_s4;
			a3_s5 <= a3_s4;
			y0_s5 <= y0_s4;
			t_s5  <= t_s4;
		end
		if (ctl.ld_s6) begin
			p2_s6 <= v1 * tx_s5;
			pl_s6 <= pl_s5;
			a2_s6 <= a2_s5;
			a3_s6 <= a3_s5;
			y0_s6 <= y0_s5;
			t_s6  <= t_s5;
		end
		if (ctl.ld_s7) begin
			p3_s7 <= v2 * tx_s6;
			pl_s7 <= pl_s6;
			a3_s7 <= a3_s6;
			y0_s7 <= y0_s6;
		end
		if (ctl.ld_s8) begin
			step_s8 <= y0_s7;
			lin_s8  <= sat_out(lin);
			cub_s8  <= sat_out(v3);
		end
	end

	assign result = {cub_s8, lin_s8, step_s8};

endmodule

FILE: tb/pitp_result_checker.sv
// Scoreboard for the phase-indexed table interpolator: tracks the point table and
// point count from observed transfers, predicts each evaluate result and compares.
// Depends on pitp_pkg for widths, point type and item kind codes.
`timescale 1ns / 100ps

module pitp_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [pitp_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [pitp_pkg::M_DATA_W-1:0]   m_tdata,
	input  logic                            cfg_wen,
	input  logic [pitp_pkg::CNT_W-1:0]      cfg_wdata,
	output int                              fail_count,
	output int                              pending
);
	import pitp_pkg::*;

	typedef struct packed {
		point_t step;
		point_t linear;
		point_t cubic;
	} interp_result_t;

	point_t           points [MAX_POINTS];
	logic [CNT_W-1:0] point_count;
	interp_result_t   expected_q [$];
	interp_result_t   want;
	point_t           got_step, got_linear, got_cubic;

	function automatic point_t sat_point(input longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return point_t'(v);
	endfunction

	// Arithmetic right shift on longint floors, as the hardware must.
	function automatic interp_result_t interpolate(input logic [PHASE_W-1:0] phase);
		longint n, prod, idx, t, y0, y1, y2, y3, a0, a1, a2, a3, v, lin;
		interp_result_t r;
		n = point_count;
		if (n < 2)
			n = 2;
		if (n > MAX_POINTS)
			n = MAX_POINTS;
		prod = longint'(phase) * n;
		idx  = (prod >>> 16) % n;
		t    = prod & 64'hFFFF;
		y0 = points[int'(idx)];
		y1 = points[int'((idx + 1) % n)];
		y2 = points[int'((idx + 2) % n)];
		y3 = points[int'((idx + 3) % n)];
		lin = y0 + ((t * (y1 - y0)) >>> 16);
		a0 = y3 - y2 - y0 + y1;
		a1 = y0 - y1 - a0;
		a2 = y2 - y0;
		a3 = y1;
		v = a0;
		v = ((v * t) >>> 16) + a1;
		v = ((v * t) >>> 16) + a2;
		v = ((v * t) >>> 16) + a3;
		r.step   = sat_point(y0);
		r.linear = sat_point(lin);
		r.cubic  = sat_point(v);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_POINTS; i++)
				points[i] = '0;
			point_count = CNT_RESET;
			expected_q.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			// retire the output transfer before queuing this edge's input
			if (m_tvalid && m_tready) begin
				got_step   = m_tdata[15:0];
				got_linear = m_tdata[31:16];
				got_cubic  = m_tdata[47:32];
				if (expected_q.size() == 0) begin
					$error("unexpected result transfer, m_tdata = %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (got_step !== want.step) begin
						$error("step_value: expected %0d, actual %0d", want.step, got_step);
						fail_count++;
					end
					if (got_linear !== want.linear) begin
						$error("linear_value: expected %0d, actual %0d", want.linear,
							got_linear);
						fail_count++;
					end
					if (got_cubic !== want.cubic) begin
						$error("cubic_value: expected %0d, actual %0d", want.cubic, got_cubic);
						fail_count++;
					end
				end
			end
			if (cfg_wen)
				point_count = cfg_wdata;
			if (s_tvalid && s_tready) begin
				if (s_tuser == FUNC_WRITE)
					points[s_tdata[3:0]] = point_t'(s_tdata[19:4]);
				else
					expected_q.push_back(interpolate(s_tdata[35:20]));
			end
			pending = expected_q.size();
		end
	end

endmodule

FILE: tb/phase_indexed_table_interpolator_core_tb.sv
// Top of the interpolator testbench: clock, reset, stimulus and verdict.
// Depends on pitp_pkg, the DUT phase_indexed_table_interpolator_core and pitp_result_checker.
`timescale 1ns / 100ps

module phase_indexed_table_interpolator_core_tb;
	import pitp_pkg::*;

	localparam int SETTLE_CYCLES = 12;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                cfg_wen;
	logic [CNT_W-1:0]    cfg_wdata;
	int                  fail_count;
	int                  pending;
	logic                sender_steady;

	always #4 clk = ~clk;

	phase_indexed_table_interpolator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	pitp_result_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Offer one item from a falling edge and hold it until the transfer.
	task automatic send_item(input logic func, input logic [IDX_W-1:0] pidx,
		input logic [POINT_W-1:0] pval, input logic [PHASE_W-1:0] phase);
		int gap, r;
		gap = 0;
		if (!sender_steady) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				gap = $urandom_range(6, 24);
			else if (r >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = func;
		s_tdata  = {4'b0, phase, pval, pidx};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	function automatic logic [POINT_W-1:0] pick_point();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'h7FFF;
		if (r < 20)
			return 16'h8000;
		if (r < 25)
			return '0;
		return POINT_W'($urandom);
	endfunction

	function automatic logic [PHASE_W-1:0] pick_phase();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return PHASE_W'($urandom);
	endfunction

	// Drain: nothing outstanding, then cover the latency of trailing writes.
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_point_count(input logic [CNT_W-1:0] value);
		wait_drained();
		cfg_wen   = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	// Receiver: random stalls, steady stretches, and a periodic long hold-off
	// that lets the pipeline fill and back-pressure the sender.
	initial begin
		int cyc, hold, stall, r;
		logic steady;
		m_tready = 1'b0;
		cyc = 0;
		hold = 0;
		stall = 0;
		steady = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 400 == 0)
				steady = ($urandom_range(0, 2) == 0);
			if (cyc % 2500 == 1200)
				hold = 150;
			if (hold > 0) begin
				hold--;
				m_tready = 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_tready = 1'b0;
			end else if (steady) begin
				m_tready = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_tready = 1'b1;
				end else if (r < 95) begin
					stall = $urandom_range(0, 2);
					m_tready = 1'b0;
				end else begin
					stall = $urandom_range(7, 29);
					m_tready = 1'b0;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("** phase_indexed_table_interpolator_core: FAILED **");
		$finish;
	end

	initial begin
		int counts [12];
		logic [PHASE_W-1:0] edge_phases [7];
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = FUNC_WRITE;
		cfg_wen       = 1'b0;
		cfg_wdata     = '0;
		sender_steady = 1'b1;
		counts = '{16, 2, 0, 31, 1, 17, 3, 9, 16, 5, 0, 0};
		counts[10] = $urandom_range(2, 16);
		counts[11] = $urandom_range(0, 31);
		edge_phases = '{16'h0000, 16'h0001, 16'h4000, 16'h7FFF, 16'h8000, 16'hC000, 16'hFFFF};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset table read, full-scale alternating points so the cubic
		// saturates, last entry write, phase extremes, write then evaluate
		send_item(FUNC_EVAL, 4'd0, 16'h0000, 16'hA5A5);
		set_point_count(CNT_W'(4));
		send_item(FUNC_WRITE, 4'd0, 16'h7FFF, 16'h0000);
		send_item(FUNC_WRITE, 4'd1, 16'h8000, 16'h0000);
		send_item(FUNC_WRITE, 4'd2, 16'h7FFF, 16'h0000);
		send_item(FUNC_WRITE, 4'd3, 16'h8000, 16'h0000);
		send_item(FUNC_WRITE, 4'd15, 16'h1234, 16'h0000);
		foreach (edge_phases[i])
			send_item(FUNC_EVAL, 4'd0, 16'h0000, edge_phases[i]);
		send_item(FUNC_WRITE, 4'd1, 16'h0000, 16'hFFFF);
		send_item(FUNC_EVAL, 4'hF, 16'hFFFF, 16'h6000);
		send_item(FUNC_WRITE, 4'd2, 16'h8000, 16'h0000);
		send_item(FUNC_EVAL, 4'd0, 16'h0000, 16'hE000);

		// random: one setting per pass, extremes and out-of-range counts included
		foreach (counts[p]) begin
			set_point_count(CNT_W'(counts[p]));
			for (int k = 0; k < 108; k++) begin
				if (k % 36 == 0)
					sender_steady = ($urandom_range(0, 2) == 0);
				if ($urandom_range(0, 99) < 30)
					send_item(FUNC_WRITE, IDX_W'($urandom_range(0, 15)), pick_point(),
						PHASE_W'($urandom));
				else
					send_item(FUNC_EVAL, IDX_W'($urandom), POINT_W'($urandom),
						pick_phase());
			end
		end

		wait_drained();
		if (fail_count == 0 && pending == 0)
			$display("** phase_indexed_table_interpolator_core: PASSED **");
		else
			$display("** phase_indexed_table_interpolator_core: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
src/pitp_pkg.sv
src/pitp_ram.sv
src/pitp_table.sv
src/pitp_interp.sv
src/phase_indexed_table_interpolator_core.sv
tb/pitp_result_checker.sv
tb/phase_indexed_table_interpolator_core_tb.sv
